// ===== sv/afp_pkg.sv =====
package afp_pkg;

  // Word sizes of the serial datapath.
  localparam int TICK_W   = 64;
  localparam int IV_W     = 32;
  localparam int DIV_W    = 40;
  localparam int CNT_W    = 6;
  localparam int SLOT_W   = 4;

  // Port payload widths.
  localparam int IN_DATA_W  = 136;
  localparam int IN_USER_W  = 1;
  localparam int OUT_DATA_W = 160;
  localparam int OUT_USER_W = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Output tdata field positions.
  localparam int SLOT_LSB   = 32;
  localparam int RATE_LSB   = 36;
  localparam int FRAMES_LSB = 52;
  localparam int IV_LSB     = 60;
  localparam int REL_LSB    = 92;

  // Phase lengths in cycles.
  localparam int MEASURE_LEN = 64;
  localparam int AVG_LEN     = 64;
  localparam int RATE_LEN    = 40;
  localparam int UPDATE_LEN  = 64;

  localparam int DELTA_SLOTS = 10;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(DELTA_SLOTS - 1);

  localparam logic [31:0] TICK_FREQ_RST = 32'd19200000;
  localparam logic [15:0] MARGIN_RST    = 16'd6000;
  localparam logic [7:0]  STEP_RST      = 8'd20;
  localparam logic [7:0]  LIMIT_RST     = 8'd200;

  localparam logic [7:0]  TARGET_MAX = 8'd60;
  localparam logic [16:0] ROUND_HALF = 17'd128;
  localparam logic [4:0]  DIV_TEN    = 5'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TICK_FREQ,
    REG_MARGIN,
    REG_STEP,
    REG_LIMIT
  } afp_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MEASURE,
    ST_AVG,
    ST_RATE,
    ST_UPDATE,
    ST_WRITE
  } afp_state_t;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_SUB,
    OP_KEEP,
    OP_ZERO
  } afp_op_t;

  typedef struct packed {
    afp_state_t       state;
    logic [CNT_W-1:0] cnt;
    logic             last;
  } afp_ctl_t;

  // One bit of each serial operand, least significant first.
  typedef struct packed {
    logic arr;
    logic done;
    logic last_end;
    logic win_start;
    logic avg;
    logic pace;
    logic tfreq;
  } afp_bits_t;

endpackage

// ===== sv/afp_seq.sv =====
module afp_seq import afp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  logic     out_free,
  output afp_ctl_t ctl
);

  afp_state_t       state;
  afp_state_t       state_next;
  logic [CNT_W-1:0] cnt;
  logic             last;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:    if (start) state_next = ST_MEASURE;
      ST_MEASURE: if (last) state_next = ST_AVG;
      ST_AVG:     if (last) state_next = ST_RATE;
      ST_RATE:    if (last) state_next = ST_UPDATE;
      ST_UPDATE:  if (last) state_next = ST_WRITE;
      ST_WRITE:   if (out_free) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    case (state)
      ST_MEASURE: last = (cnt == CNT_W'(MEASURE_LEN - 1));
      ST_AVG:     last = (cnt == CNT_W'(AVG_LEN - 1));
      ST_RATE:    last = (cnt == CNT_W'(RATE_LEN - 1));
      ST_UPDATE:  last = (cnt == CNT_W'(UPDATE_LEN - 1));
      default:    last = 1'b0;
    endcase
    ctl.state = state;
    ctl.cnt   = cnt;
    ctl.last  = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (last || state == ST_IDLE || state == ST_WRITE) begin
        cnt <= '0;
      end else begin
        cnt <= cnt + 1'b1;
      end
    end
  end

endmodule

// ===== sv/afp_front.sv =====
module afp_front import afp_pkg::*; (
  input  logic      clk,
  input  logic      clr,
  input  afp_ctl_t  ctl,
  input  afp_bits_t bits,
  output logic      delta_b,
  output logic      avg_q,
  output logic      lt_pace,
  output logic      past_window
);

  // Borrow flops of the serial subtractors.
  logic              bw_gap;
  logic              bw_held;
  logic              bw_delta;
  logic              bw_span;
  logic              bw_tf;
  // Carry and three-bit delay line of the 9*avg + delta adder.
  logic [1:0]        sc;
  logic [2:0]        adl;
  logic [TICK_W-1:0] s_sh;
  logic [3:0]        rem;

  logic       gap;
  logic       span;
  logic [2:0] ssum;
  logic [3:0] hi;
  logic [3:0] rem_cur;
  logic [4:0] trial;
  logic       ge;
  logic [3:0] rem_next;

  always_comb begin
    gap      = bits.arr ^ bits.last_end ^ bw_gap;
    delta_b  = bits.done ^ bits.last_end ^ bw_delta;
    span     = bits.done ^ bits.win_start ^ bw_span;
    ssum     = 3'(bits.avg) + 3'(adl[2]) + 3'(delta_b) + 3'(sc);
    // Bits 64..66 of 9*avg are the last three avg bits, plus the carry left over.
    hi       = {1'b0, adl[0], adl[1], adl[2]} + 4'(sc);
    rem_cur  = (ctl.cnt == '0) ? hi : rem;
    trial    = {rem_cur, s_sh[TICK_W-1]};
    ge       = (trial >= DIV_TEN);
    rem_next = ge ? 4'(trial - DIV_TEN) : trial[3:0];
  end

  assign avg_q       = ge;
  assign lt_pace     = bw_held;
  assign past_window = bw_tf;

  always_ff @(posedge clk) begin
    if (clr) begin
      bw_gap   <= 1'b0;
      bw_held  <= 1'b0;
      bw_delta <= 1'b0;
      bw_span  <= 1'b0;
      bw_tf    <= 1'b0;
      sc       <= '0;
      adl      <= '0;
    end else if (ctl.state == ST_MEASURE) begin
      bw_gap   <= (~bits.arr & bits.last_end) | (~(bits.arr ^ bits.last_end) & bw_gap);
      bw_held  <= (~gap & bits.pace) | (~(gap ^ bits.pace) & bw_held);
      bw_delta <= (~bits.done & bits.last_end) | (~(bits.done ^ bits.last_end) & bw_delta);
      bw_span  <= (~bits.done & bits.win_start) | (~(bits.done ^ bits.win_start) & bw_span);
      bw_tf    <= (~bits.tfreq & span) | (~(bits.tfreq ^ span) & bw_tf);
      sc       <= ssum[2:1];
      adl      <= {adl[1:0], bits.avg};
      s_sh     <= {ssum[0], s_sh[TICK_W-1:1]};
    end else if (ctl.state == ST_AVG) begin
      s_sh     <= {s_sh[TICK_W-2:0], 1'b0};
      rem      <= rem_next;
    end
  end

endmodule

// ===== sv/afp_div.sv =====
module afp_div import afp_pkg::*; (
  input  logic              clk,
  input  logic              load,
  input  logic              step,
  input  logic [DIV_W-1:0]  num,
  input  logic [TICK_W-1:0] den,
  output logic [DIV_W-1:0]  quo
);

  logic [DIV_W-1:0] num_sh;
  logic [DIV_W-1:0] rem;
  logic [DIV_W:0]   trial;
  logic             fits;
  logic             ge;

  // The partial remainder never exceeds the numerator prefix, so a divisor
  // above DIV_W+1 bits can never be subtracted.
  always_comb begin
    trial = {rem, num_sh[DIV_W-1]};
    fits  = ~|den[TICK_W-1:DIV_W+1];
    ge    = fits && (trial >= den[DIV_W:0]);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      num_sh <= num;
      rem    <= '0;
      quo    <= '0;
    end else if (step) begin
      num_sh <= {num_sh[DIV_W-2:0], 1'b0};
      rem    <= ge ? DIV_W'(trial - den[DIV_W:0]) : trial[DIV_W-1:0];
      quo    <= {quo[DIV_W-2:0], ge};
    end
  end

endmodule

// ===== sv/afp_tail.sv =====
module afp_tail import afp_pkg::*; (
  input  logic              clk,
  input  afp_ctl_t          ctl,
  input  logic              prep,
  input  afp_op_t           mode,
  input  logic [IV_W-1:0]   opa,
  input  logic [IV_W-1:0]   opb,
  input  logic              done_b,
  output logic [IV_W-1:0]   interval,
  output logic [TICK_W-1:0] next_rel
);

  logic [IV_W-1:0] opa_sh;
  logic [IV_W-1:0] opb_sh;
  logic            cf;
  logic            cr;
  logic            lo;
  logic            a;
  logic            b;
  logic            r;
  logic            iv;
  logic            rb;
  logic            cf_next;

  always_comb begin
    lo = (ctl.cnt < CNT_W'(IV_W));
    a  = opa_sh[0];
    b  = (mode == OP_KEEP) ? 1'b0 : opb_sh[0];
    r  = a ^ b ^ cf;
    case (mode)
      OP_SUB:  cf_next = (~a & b) | (~(a ^ b) & cf);
      default: cf_next = (a & b) | (a & cf) | (b & cf);
    endcase
    iv = lo && (mode != OP_ZERO) && r;
    rb = done_b ^ iv ^ cr;
  end

  always_ff @(posedge clk) begin
    if (prep) begin
      opa_sh <= opa;
      opb_sh <= opb;
      cf     <= 1'b0;
      cr     <= 1'b0;
    end else if (ctl.state == ST_UPDATE) begin
      opa_sh   <= {1'b0, opa_sh[IV_W-1:1]};
      opb_sh   <= {1'b0, opb_sh[IV_W-1:1]};
      cf       <= cf_next;
      cr       <= (done_b & iv) | (done_b & cr) | (iv & cr);
      next_rel <= {rb, next_rel[TICK_W-1:1]};
      if (lo) begin
        interval <= {iv, interval[IV_W-1:1]};
      end
    end
  end

endmodule

// ===== sv/adaptive_frame_pacer.sv =====
// Adaptive frame pacer. Each input transfer is one frame-present event; each
// one yields exactly one output transfer with the frame length, its ring slot,
// the averaged frame rate in unsigned Q8.8, the one-second window report, the
// hold flag and the updated pacing interval with the release tick of the next
// frame. The block works on one event at a time: it accepts an event, then
// spends the measure phase on bit-serial measurement of the tick differences,
// the average phase dividing the new moving-average sum by ten one bit at a
// time, the rate phase on the one-bit-per-cycle rate division, the update
// phase updating the interval and the release tick serially, and then writes
// the result. The write, and with it the next transfer in, waits until the
// result of the event before has left the result register or leaves it in the
// same cycle. The result register lets the next event start while a result
// still waits. Configuration writes go straight to the registers and must
// only be made while the block is idle.
module adaptive_frame_pacer import afp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // Input events.
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [63:0] arrival_tick, [127:64] present_done_tick, [135:128] target_fps
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // [0] delay_blocked
  input  logic [IN_USER_W-1:0]  s_axis_tuser,
  // Results.
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [31:0] frame_ticks, [35:32] delta_slot, [51:36] avg_rate_q8,
  // [59:52] frames_last_second, [91:60] interval_ticks,
  // [155:92] next_release_tick, [159:156] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // [0] frame_was_held, [1] second_done
  output logic [OUT_USER_W-1:0] m_axis_tuser,
  // Configuration writes.
  input  logic                  cfg_wen,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers.
  logic [31:0] tfreq;
  logic [15:0] margin;
  logic [7:0]  tstep;
  logic [7:0]  limit;

  // Pacer state.
  logic              started;
  logic [TICK_W-1:0] ws;
  logic [TICK_W-1:0] last_end;
  logic [TICK_W-1:0] avg;
  logic [7:0]        count;
  logic [7:0]        active_target;
  logic [IV_W-1:0]   pace;
  logic [SLOT_W-1:0] slot;
  logic [7:0]        adj;

  // Working registers of the event being processed.
  logic [TICK_W-1:0] arr_sh;
  logic [TICK_W-1:0] done_sh;
  logic [7:0]        target_r;
  logic              blocked_r;
  logic [IV_W-1:0]   pace_sh;
  logic [IV_W-1:0]   tf_sh;
  logic [IV_W-1:0]   ft_sh;

  // Result register.
  logic                  out_valid;
  logic [OUT_DATA_W-1:0] out_data;
  logic [OUT_USER_W-1:0] out_user;

  afp_ctl_t          ctl;
  afp_bits_t         bits;
  afp_op_t           mode;
  logic              start;
  logic              out_free;
  logic              commit;
  logic              prep;
  logic              delta_b;
  logic              avg_q;
  logic              lt_pace;
  logic              closed;
  logic [DIV_W-1:0]  reload_q;
  logic [DIV_W-1:0]  rate_q;
  logic [15:0]       rate;
  logic [15:0]       lock;
  logic              held;
  logic              up;
  logic              dn;
  logic              reload;
  logic              in_range;
  logic [IV_W-1:0]   opa;
  logic [IV_W-1:0]   opb;
  logic [IV_W-1:0]   interval;
  logic [TICK_W-1:0] next_rel;
  logic [7:0]        frames;

  assign start         = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (ctl.state == ST_IDLE) && !rst;
  assign out_free      = !out_valid || m_axis_tready;
  assign commit        = (ctl.state == ST_WRITE) && out_free;
  assign prep          = (ctl.state == ST_RATE) && ctl.last;

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign m_axis_tuser  = out_user;

  afp_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .out_free (out_free),
    .ctl      (ctl)
  );

  // Serial operand bits, least significant first. Before the first frame the
  // window opens at the arrival tick of that frame.
  always_comb begin
    bits.arr       = arr_sh[0];
    bits.done      = done_sh[0];
    bits.last_end  = last_end[0];
    bits.win_start = started ? ws[0] : arr_sh[0];
    bits.avg       = avg[0];
    bits.pace      = pace_sh[0];
    bits.tfreq     = tf_sh[0];
  end

  afp_front u_front (
    .clk         (clk),
    .clr         (start),
    .ctl         (ctl),
    .bits        (bits),
    .delta_b     (delta_b),
    .avg_q       (avg_q),
    .lt_pace     (lt_pace),
    .past_window (closed)
  );

  // Ideal interval for a new target, computed while the event is measured.
  afp_div u_reload_div (
    .clk  (clk),
    .load (start),
    .step ((ctl.state == ST_MEASURE) && (ctl.cnt < CNT_W'(RATE_LEN))),
    .num  (DIV_W'(tfreq)),
    .den  (TICK_W'(target_r)),
    .quo  (reload_q)
  );

  // Rate in Q8.8 from the new average. A zero average makes every quotient bit
  // one, which lands on the saturation value.
  afp_div u_rate_div (
    .clk  (clk),
    .load (ctl.state == ST_AVG),
    .step (ctl.state == ST_RATE),
    .num  ({tfreq, 8'h00}),
    .den  (avg),
    .quo  (rate_q)
  );

  // Adaptive decision. A held frame whose rate beats the target stretches the
  // interval; one that only rounds up to the target shrinks it again.
  always_comb begin
    rate     = (|rate_q[DIV_W-1:16]) ? 16'hFFFF : rate_q[15:0];
    lock     = {active_target, 8'h00};
    held     = lt_pace && (|pace) && !blocked_r;
    up       = held && (rate > lock) && (adj < limit);
    dn       = held && (rate < lock) && ((17'(rate) + ROUND_HALF) >= 17'(lock)) && (adj != '0);
    reload   = (target_r != active_target);
    in_range = (target_r != '0) && (target_r < TARGET_MAX);
    opa      = (reload && in_range) ? reload_q[IV_W-1:0] : pace;
    opb      = reload ? IV_W'(margin) : IV_W'(tstep);
    if (reload) begin
      mode = in_range ? OP_SUB : OP_ZERO;
    end else if (up) begin
      mode = OP_ADD;
    end else if (dn) begin
      mode = OP_SUB;
    end else begin
      mode = OP_KEEP;
    end
    frames = closed ? count : 8'h00;
  end

  afp_tail u_tail (
    .clk      (clk),
    .ctl      (ctl),
    .prep     (prep),
    .mode     (mode),
    .opa      (opa),
    .opb      (opb),
    .done_b   (done_sh[0]),
    .interval (interval),
    .next_rel (next_rel)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      tfreq  <= TICK_FREQ_RST;
      margin <= MARGIN_RST;
      tstep  <= STEP_RST;
      limit  <= LIMIT_RST;
    end else if (cfg_wen) begin
      case (afp_reg_t'(cfg_idx))
        REG_TICK_FREQ: tfreq  <= cfg_data;
        REG_MARGIN:    margin <= cfg_data[15:0];
        REG_STEP:      tstep  <= cfg_data[7:0];
        REG_LIMIT:     limit  <= cfg_data[7:0];
        default:       tfreq  <= tfreq;
      endcase
    end
  end

  // Working shift registers. The done tick rotates twice over 64 bits, so it
  // is whole again when the result is written.
  always_ff @(posedge clk) begin
    if (start) begin
      arr_sh    <= s_axis_tdata[TICK_W-1:0];
      done_sh   <= s_axis_tdata[2*TICK_W-1:TICK_W];
      target_r  <= s_axis_tdata[2*TICK_W+7:2*TICK_W];
      blocked_r <= s_axis_tuser[0];
      pace_sh   <= pace;
      tf_sh     <= tfreq;
    end else if (ctl.state == ST_MEASURE) begin
      arr_sh  <= {1'b0, arr_sh[TICK_W-1:1]};
      done_sh <= {done_sh[0], done_sh[TICK_W-1:1]};
      pace_sh <= {1'b0, pace_sh[IV_W-1:1]};
      tf_sh   <= {1'b0, tf_sh[IV_W-1:1]};
      if (ctl.cnt < CNT_W'(IV_W)) begin
        ft_sh <= {delta_b, ft_sh[IV_W-1:1]};
      end
    end else if (ctl.state == ST_UPDATE) begin
      done_sh <= {done_sh[0], done_sh[TICK_W-1:1]};
    end
  end

  // Pacer state. The last end tick is replaced by the done tick bit by bit
  // while it is being read; the average is rebuilt from the divide-by-ten.
  always_ff @(posedge clk) begin
    if (rst) begin
      started       <= 1'b0;
      ws            <= '0;
      last_end      <= '0;
      avg           <= '0;
      count         <= '0;
      active_target <= '0;
      pace          <= '0;
      slot          <= '0;
      adj           <= '0;
    end else begin
      if (ctl.state == ST_MEASURE) begin
        last_end <= {done_sh[0], last_end[TICK_W-1:1]};
        ws       <= {bits.win_start, ws[TICK_W-1:1]};
        avg      <= {avg[0], avg[TICK_W-1:1]};
      end else if (ctl.state == ST_AVG) begin
        avg <= {avg[TICK_W-2:0], avg_q};
      end
      if (commit) begin
        started       <= 1'b1;
        active_target <= target_r;
        pace          <= interval;
        slot          <= (slot == LAST_SLOT) ? '0 : slot + 1'b1;
        if (closed) begin
          ws    <= done_sh;
          count <= '0;
        end else begin
          count <= count + 1'b1;
        end
        if (up) begin
          adj <= adj + 1'b1;
        end else if (dn) begin
          adj <= adj - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_data <= {4'h0, next_rel, interval, frames, rate, slot, ft_sh};
      out_user <= {closed, held};
    end
  end

endmodule

// ===== sv/afp_checker.sv =====
module afp_checker import afp_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic [OUT_USER_W-1:0] m_axis_tuser
);

  // Events are processed one at a time.
  a_one_event: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while an event is in progress");

  // The frame count is only reported when a window closed.
  a_frames_quiet: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[1] |-> m_axis_tdata[FRAMES_LSB+7:FRAMES_LSB] == 8'h00)
    else $error("frame count reported without a closed window");

  // The ring slot stays inside the ring.
  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[SLOT_LSB+SLOT_W-1:SLOT_LSB] <= LAST_SLOT)
    else $error("ring slot out of range");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

endmodule

bind adaptive_frame_pacer afp_checker u_afp_checker (.*);

// ===== tb/sv/adaptive_frame_pacer_tb.sv =====
module adaptive_frame_pacer_tb;
  import afp_pkg::*;

  // A result can wait behind the longest receiver stall while the block is
  // still busy with the next event, so the watchdog allows several times the
  // worst quiet stretch that a correct run can show.
  localparam int STALL_LIMIT   = 5000;
  // Cycles let pass after the last result before registers are touched or
  // the run is closed: a little more than one full event of the block.
  localparam int SETTLE_CYCLES = 300;

  // One result of the block, field by field.
  typedef struct {
    bit        held;
    bit        closed;
    bit [31:0] frame_len;
    bit [3:0]  slot;
    bit [15:0] rate;
    bit [7:0]  frames;
    bit [31:0] interval;
    bit [63:0] release_at;
  } pace_result_t;

  // One row of the directed part. Rows marked typed carry a result worked
  // out by hand; the others are checked against the pacing predictor.
  typedef struct {
    bit [63:0]    arr;
    bit [63:0]    done;
    bit [7:0]     tgt;
    bit           blk;
    bit           typed;
    pace_result_t want;
  } frame_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [IN_USER_W-1:0]  s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b1;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [OUT_USER_W-1:0] m_axis_tuser;
  logic                  cfg_wen = 1'b0;
  afp_reg_t              cfg_idx = REG_TICK_FREQ;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Register copies held by the predictor.
  bit [31:0] ticks_per_sec = TICK_FREQ_RST;
  bit [15:0] margin_ticks  = MARGIN_RST;
  bit [7:0]  step_ticks    = STEP_RST;
  bit [7:0]  nudge_budget  = LIMIT_RST;

  // Pacing state of the predictor, all cleared by reset.
  bit        seen_first    = 1'b0;
  bit [63:0] window_origin = '0;
  bit [63:0] prev_end      = '0;
  bit [63:0] mean_len      = '0;
  bit [7:0]  window_count  = '0;
  bit [7:0]  locked_target = '0;
  bit [31:0] pacing        = '0;
  bit [3:0]  ring_pos      = '0;
  bit [7:0]  nudges        = '0;

  pace_result_t awaited[$];       // results still owed by the block, oldest first
  frame_row_t   plan[$];          // directed stimulus
  bit [63:0]    feed_end = '0;    // end tick of the last frame sent
  bit           idle_on = 1'b0;   // random gaps on both sides when set
  int           stall_left = 0;
  int           frames_sent = 0;
  int           results_seen = 0;
  int           mismatches = 0;
  int           quiet_cycles = 0;

  adaptive_frame_pacer dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_wen       (cfg_wen),
    .cfg_idx       (cfg_idx),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Works out the result of one frame event and advances the pacing state.
  function automatic pace_result_t predict_frame(input bit [63:0] arr, input bit [63:0] done,
                                                 input bit [7:0] tgt, input bit blk);
    pace_result_t r;
    bit [63:0]    len;
    bit [67:0]    mix;
    bit [63:0]    quot;
    bit [16:0]    lock;
    bit [16:0]    rate_w;
    r = '{default: '0};
    if (!seen_first) begin
      seen_first    = 1'b1;
      window_origin = arr;
    end
    // A frame is held when it shows up before the release tick of the last one.
    r.held = (pacing != 0) && !blk && ((arr - prev_end) < {32'b0, pacing});
    len = done - prev_end;
    // Nine tenths of the old average plus a tenth of the new length, floored.
    mix      = 68'(mean_len) * 68'd9 + 68'(len);
    mean_len = 64'(mix / 68'd10);
    if (mean_len == 0) begin
      r.rate = 16'hFFFF;
    end else begin
      quot   = {24'b0, ticks_per_sec, 8'b0} / mean_len;
      r.rate = (quot > 64'd65535) ? 16'hFFFF : quot[15:0];
    end
    // Held frames nudge the interval: up when running fast, down when the
    // rate sits just under the target but would still round to it.
    lock   = {1'b0, locked_target, 8'b0};
    rate_w = {1'b0, r.rate};
    if (r.held) begin
      if (rate_w > lock) begin
        if (nudges < nudge_budget) begin
          pacing = pacing + 32'(step_ticks);
          nudges = nudges + 8'd1;
        end
      end else if (rate_w < lock && rate_w + 17'd128 >= lock) begin
        if (nudges > 0) begin
          pacing = pacing - 32'(step_ticks);
          nudges = nudges - 8'd1;
        end
      end
    end
    prev_end     = done;
    window_count = window_count + 8'd1;
    r.slot       = ring_pos;
    ring_pos     = (ring_pos == LAST_SLOT) ? 4'd0 : ring_pos + 4'd1;
    if (done - window_origin > {32'b0, ticks_per_sec}) begin
      window_origin = done;
      r.frames      = window_count - 8'd1;
      window_count  = '0;
      r.closed      = 1'b1;
    end
    // A new target reloads the interval; only locks below sixty frames pace.
    if (tgt != locked_target) begin
      if (tgt != 0 && tgt < TARGET_MAX)
        pacing = ticks_per_sec / tgt - 32'(margin_ticks);
      else
        pacing = '0;
      locked_target = tgt;
    end
    r.frame_len  = len[31:0];
    r.interval   = pacing;
    r.release_at = done + {32'b0, pacing};
    return r;
  endfunction

  function automatic bit [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Most gaps are nothing or short; now and then a long one.
  function automatic int sender_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 8);
    return $urandom_range(30, 400);
  endfunction

  // Mostly locks that pace, some unlocked, some at sixty or above.
  function automatic bit [7:0] pick_target();
    int r;
    r = $urandom_range(0, 9);
    if (r < 8) return 8'($urandom_range(1, 59));
    if (r == 8) return 8'd0;
    return 8'($urandom_range(60, 255));
  endfunction

  function automatic void add_row(input bit [63:0] arr, input bit [63:0] done,
                                  input bit [7:0] tgt, input bit blk);
    frame_row_t row;
    row       = '{default: '0};
    row.arr   = arr;
    row.done  = done;
    row.tgt   = tgt;
    row.blk   = blk;
    plan.push_back(row);
  endfunction

  // Attaches a hand-worked result to the row added last.
  function automatic void typed_result(input bit held, input bit closed, input bit [31:0] len,
                                       input bit [3:0] slot, input bit [15:0] rate,
                                       input bit [7:0] frames, input bit [31:0] iv,
                                       input bit [63:0] rel);
    int last;
    last = plan.size() - 1;
    plan[last].typed = 1'b1;
    plan[last].want  = '{held, closed, len, slot, rate, frames, iv, rel};
  endfunction

  function automatic void check_field(input string what, input bit [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      if (mismatches < 10)
        $display("mismatch in %s on result %0d: expected %h, got %h",
                 what, results_seen, want, got);
      mismatches++;
    end
  endfunction

  // Offers one frame event after a random gap and waits for its transfer.
  // valid stays high when the next event follows with no gap.
  task automatic send_frame(input bit [63:0] arr, input bit [63:0] done,
                            input bit [7:0] tgt, input bit blk);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {tgt, done, arr};
    s_axis_tuser  <= blk;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    awaited.push_back(predict_frame(arr, done, tgt, blk));
    feed_end = done;
    frames_sent++;
  endtask

  // A run of frames as a paced game loop would produce them: each request
  // lands somewhere within the ideal interval plus an eighth, so many are held,
  // and the frame ends jitter around the ideal interval, so the averaged rate
  // sits near the lock and both nudge directions come into play. With scramble
  // set the target is picked anew on every frame.
  task automatic paced_run(input int n, input bit [7:0] first_tgt, input bit scramble);
    bit [7:0]  tgt;
    bit [63:0] span;
    bit [63:0] jmax;
    bit [63:0] arr_off;
    bit [63:0] len_off;
    bit [95:0] prod;
    tgt = first_tgt;
    for (int i = 0; i < n; i++) begin
      if (scramble) tgt = pick_target();
      span    = 64'(ticks_per_sec / ((tgt == 0) ? 8'd30 : tgt));
      jmax    = span >> ($urandom_range(0, 1) ? 5 : 9);
      prod    = 96'($urandom) * 96'(span + (span >> 3));
      arr_off = prod[95:32];
      len_off = span - jmax + 64'($urandom_range(0, 32'(2 * jmax)));
      if (len_off < arr_off) len_off = arr_off + 64'($urandom_range(0, 50));
      send_frame(feed_end + arr_off, feed_end + len_off, tgt, $urandom_range(0, 9) == 0);
    end
  endtask

  // Very short frames with no lock: drives the rate into saturation and,
  // with a short second, lets the per-window count wrap.
  task automatic tiny_frames(input int n);
    for (int i = 0; i < n; i++)
      send_frame(feed_end + 64'($urandom_range(0, 10)), feed_end + 64'($urandom_range(1, 38)),
                 8'd0, 1'($urandom));
  endtask

  // Random part of one phase: mostly well-formed paced runs, some noise
  // frames with arbitrary fields, some runs with a jumping target.
  task automatic random_mix(input int quota);
    int stop_at;
    int kind;
    stop_at = frames_sent + quota;
    while (frames_sent < stop_at) begin
      kind = $urandom_range(0, 99);
      if (kind < 70)
        paced_run($urandom_range(5, 40), pick_target(), 1'b0);
      else if (kind < 85)
        repeat ($urandom_range(1, 4)) send_frame(rand64(), rand64(), 8'($urandom), 1'($urandom));
      else if (kind < 95)
        paced_run($urandom_range(3, 10), 8'd0, 1'b1);
      else
        tiny_frames($urandom_range(10, 40));
    end
  endtask

  // Stops the sender, waits for every owed result, then lets the block go
  // quiet before anything else happens.
  task automatic settle();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (awaited.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes all four registers on consecutive cycles; the block is idle here.
  task automatic program_regs(input bit [31:0] tf, input bit [15:0] mg,
                              input bit [7:0] st, input bit [7:0] lim);
    @(negedge clk);
    cfg_wen  <= 1'b1;
    cfg_idx  <= REG_TICK_FREQ;
    cfg_data <= tf;
    @(negedge clk);
    cfg_idx  <= REG_MARGIN;
    cfg_data <= 32'(mg);
    @(negedge clk);
    cfg_idx  <= REG_STEP;
    cfg_data <= 32'(st);
    @(negedge clk);
    cfg_idx  <= REG_LIMIT;
    cfg_data <= 32'(lim);
    @(negedge clk);
    cfg_wen <= 1'b0;
    ticks_per_sec = tf;
    margin_ticks  = mg;
    step_ticks    = st;
    nudge_budget  = lim;
  endtask

  // Receiver side: ready drops for random stretches, mostly short ones.
  always @(negedge clk) begin
    if (!idle_on) begin
      m_axis_tready <= 1'b1;
      stall_left    <= 0;
    end else if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else if ($urandom_range(0, 7) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= ($urandom_range(0, 49) == 0) ? $urandom_range(40, 500)
                                                     : $urandom_range(0, 5);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Every result transfer is compared with the oldest owed result.
  always @(posedge clk) begin : watch_results
    pace_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (awaited.size() == 0) begin
        if (mismatches < 10)
          $display("result %0d arrived with nothing owed: tdata %h tuser %b",
                   results_seen, m_axis_tdata, m_axis_tuser);
        mismatches++;
      end else begin
        want = awaited.pop_front();
        check_field("frame_was_held", 64'(want.held), 64'(m_axis_tuser[0]));
        check_field("second_done", 64'(want.closed), 64'(m_axis_tuser[1]));
        check_field("frame_ticks", 64'(want.frame_len), 64'(m_axis_tdata[31:0]));
        check_field("delta_slot", 64'(want.slot), 64'(m_axis_tdata[SLOT_LSB +: 4]));
        check_field("avg_rate_q8", 64'(want.rate), 64'(m_axis_tdata[RATE_LSB +: 16]));
        check_field("frames_last_second", 64'(want.frames),
                    64'(m_axis_tdata[FRAMES_LSB +: 8]));
        check_field("interval_ticks", 64'(want.interval), 64'(m_axis_tdata[IV_LSB +: 32]));
        check_field("next_release_tick", want.release_at, m_axis_tdata[REL_LSB +: 64]);
        check_field("tdata padding", 64'd0, 64'(m_axis_tdata[OUT_DATA_W-1:REL_LSB+64]));
      end
    end
  end

  // Watchdog: too long without any transfer on either stream ends the run.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("no transfer for %0d cycles, %0d results still owed",
               quiet_cycles, awaited.size());
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    bit [31:0] tf;

    // Directed rows. The first three follow from the reset state at a
    // glance: with a zero average the rate saturates, a lock of sixty means
    // no pacing, and a lock of thirty loads 640000 less the 6000 margin.
    add_row(64'd0, 64'd5, 8'd0, 1'b0);
    typed_result(1'b0, 1'b0, 32'd5, 4'd0, 16'hFFFF, 8'd0, 32'd0, 64'd5);
    add_row(64'd5, 64'd5, 8'd60, 1'b0);
    typed_result(1'b0, 1'b0, 32'd0, 4'd1, 16'hFFFF, 8'd0, 32'd0, 64'd5);
    add_row(64'd5, 64'd6, 8'd30, 1'b1);
    typed_result(1'b0, 1'b0, 32'd1, 4'd2, 16'hFFFF, 8'd0, 32'd634000, 64'd634006);
    // Early request, so the frame is held; then the same but hold blocked.
    add_row(64'd100, 64'd640006, 8'd30, 1'b0);
    add_row(64'd640010, 64'd1280006, 8'd30, 1'b1);
    add_row(64'd1280100, 64'd1920006, 8'd30, 1'b0);
    // Late request, not held; then a long frame that closes the window.
    add_row(64'd2620006, 64'd2620007, 8'd30, 1'b0);
    add_row(64'd2620008, 64'd25000000, 8'd59, 1'b0);
    // Ticks near the top of the range, then a frame end that wraps past zero.
    add_row(64'hFFFF_FFFF_FFFF_FFF0, 64'hFFFF_FFFF_FFFF_FFFF, 8'd1, 1'b0);
    add_row(64'hFFFF_FFFF_FFFF_FFFF, 64'd3, 8'd1, 1'b0);
    add_row(64'd4, 64'h8000_0000_0000_0000, 8'd255, 1'b1);
    add_row(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 8'hAA, 1'b0);
    add_row(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 8'h55, 1'b1);
    add_row(64'd0, 64'd0, 8'd0, 1'b0);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset values of the registers, no idling during the directed rows.
    foreach (plan[i]) begin
      send_frame(plan[i].arr, plan[i].done, plan[i].tgt, plan[i].blk);
      if (plan[i].typed) awaited[awaited.size() - 1] = plan[i].want;
    end
    idle_on = 1'b1;
    random_mix(150);

    // Widest second, no margin, largest step and budget.
    settle();
    program_regs(32'hFFFF_FFFF, 16'd0, 8'd255, 8'd255);
    random_mix(150);

    // Narrowest second and largest margin: every reload wraps. No budget,
    // no step, and no idling on either side.
    settle();
    program_regs(32'd1, 16'hFFFF, 8'd0, 8'd0);
    idle_on = 1'b0;
    random_mix(100);

    // Wrapped intervals again, with a small budget that is soon used up.
    settle();
    program_regs(32'd1000, 16'hFFFF, 8'd255, 8'd3);
    idle_on = 1'b1;
    random_mix(150);

    // A short second filled with tiny frames, so the window count wraps.
    settle();
    program_regs(32'd5200, 16'd100, 8'd1, 8'd10);
    tiny_frames(320);
    random_mix(50);

    // Arbitrary register values.
    settle();
    tf = $urandom;
    if (tf == 0) tf = 32'd1;
    program_regs(tf, 16'($urandom), 8'($urandom), 8'($urandom));
    random_mix(150);

    settle();
    if (mismatches == 0 && awaited.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
